FILE: rtl/core/vcpa_pkg.sv
// shared types and constants for the voice channel pool allocator
package vcpa_pkg;

    localparam int NUM_CHANNELS = 32;
    localparam int KEY_BITS     = 16;

    localparam int CHAN_BITS = 5;
    localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CNT_W     = $clog2(NUM_CHANNELS + 1);
    localparam int FIFO_W    = (CH_W > CHAN_BITS) ? CH_W : CHAN_BITS;
    localparam int MAP_W     = KEY_BITS + CHAN_BITS;

    localparam logic [1:0] MODE_ASSIGN  = 2'd0;
    localparam logic [1:0] MODE_ADD     = 2'd1;
    localparam logic [1:0] MODE_RELEASE = 2'd2;
    localparam logic [1:0] MODE_QUERY   = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] source_id;
        logic [4:0]  channel_in;
        logic        stop_flag;
    } t_req;

    typedef struct packed {
        logic       ok;
        logic [4:0] channel_out;
        logic       was_playing;
        logic       stop_source;
        logic [5:0] active_count;
        logic [5:0] free_count;
    } t_rsp;

endpackage

FILE: rtl/core/vcpa_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module vcpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/voice_channel_pool_allocator.sv
// Voice channel pool allocator: hands out voice channels from a FIFO free list and keeps a
// source-to-channel table. After reset the block loads the free list with channels
// 0..NUM_CHANNELS-1 and accepts no transaction until then. Each transaction is
// accepted in ST_IDLE, scans the table in ST_SCAN and completes in ST_EXEC.
// The table memory is scanned one entry per cycle through its single read port. A
// last scan step compares the read data of the last entry, and ST_EXEC then applies
// the update and loads the output register once that register is free or being drained.
// The next transaction can be accepted in the same cycle as the result appears. One
// transaction is in flight at a time; a finished result may wait in the output register
// while the next transaction is accepted and scanned.
module voice_channel_pool_allocator (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  vcpa_pkg::t_req i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output vcpa_pkg::t_rsp o_out_data
);

    localparam logic [1:0] ST_INIT = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_EXEC = 2'd3;

    localparam int CH_W   = vcpa_pkg::CH_W;
    localparam int CNT_W  = vcpa_pkg::CNT_W;
    localparam int NCH    = vcpa_pkg::NUM_CHANNELS;
    localparam int KB     = vcpa_pkg::KEY_BITS;
    localparam int CB     = vcpa_pkg::CHAN_BITS;
    localparam int FIFO_W = vcpa_pkg::FIFO_W;
    localparam int MAP_W  = vcpa_pkg::MAP_W;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NCH);
    localparam logic [CH_W-1:0]  IDX_LAST = CH_W'(NCH - 1);

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    vcpa_pkg::t_req   r_item;
    logic [KB-1:0]    r_key;
    logic             r_found, n_found;
    logic [CH_W-1:0]  r_slot, n_slot;
    logic [CB-1:0]    r_slot_chan, n_slot_chan;
    logic             r_have_free, n_have_free;
    logic [CH_W-1:0]  r_free_slot, n_free_slot;
    logic [CH_W-1:0]  r_head, n_head;
    logic [CH_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0] r_free_level, n_free_level;
    logic [CNT_W-1:0] r_map_count, n_map_count;
    logic [NCH-1:0]   r_map_vld, n_map_vld;
    logic             r_out_valid, n_out_valid;
    vcpa_pkg::t_rsp   r_out, n_out;

    logic              w_accept;
    logic              w_commit;
    logic [CH_W-1:0]   w_cmp_idx;
    logic [KB-1:0]     w_rd_key;
    logic [CB-1:0]     w_rd_chan;

    logic              w_fifo_we;
    logic [CH_W-1:0]   w_fifo_waddr;
    logic [FIFO_W-1:0] w_fifo_wdata;
    logic [FIFO_W-1:0] w_fifo_rdata;
    logic              w_map_we;
    logic              w_map_re;
    logic [MAP_W-1:0]  w_map_rdata;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_commit    = (r_state == ST_EXEC) && (!r_out_valid || i_out_ready);
    assign w_cmp_idx   = CH_W'(r_cnt - CNT_W'(1));
    assign w_rd_key    = w_map_rdata[MAP_W-1 -: KB];
    assign w_rd_chan   = w_map_rdata[CB-1:0];
    assign w_map_re    = (r_state == ST_SCAN) && (r_cnt != CNT_FULL);

    // free list, loaded with channel numbers in order after reset
    vcpa_ram #(
        .WIDTH (FIFO_W),
        .DEPTH (NCH)
    ) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (w_fifo_we),
        .i_waddr (w_fifo_waddr),
        .i_wdata (w_fifo_wdata),
        .i_re    (w_accept),
        .i_raddr (r_head),
        .o_rdata (w_fifo_rdata)
    );

    // source table: key and channel per slot, validity kept in flops
    vcpa_ram #(
        .WIDTH (MAP_W),
        .DEPTH (NCH)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (w_map_we),
        .i_waddr (r_free_slot),
        .i_wdata ({r_key, r_item.channel_in}),
        .i_re    (w_map_re),
        .i_raddr (r_cnt[CH_W-1:0]),
        .o_rdata (w_map_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_found      = r_found;
        n_slot       = r_slot;
        n_slot_chan  = r_slot_chan;
        n_have_free  = r_have_free;
        n_free_slot  = r_free_slot;
        n_head       = r_head;
        n_tail       = r_tail;
        n_free_level = r_free_level;
        n_map_count  = r_map_count;
        n_map_vld    = r_map_vld;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        w_fifo_we    = 1'b0;
        w_fifo_waddr = r_tail;
        w_fifo_wdata = FIFO_W'(r_slot_chan);
        w_map_we     = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_INIT: begin
                w_fifo_we    = 1'b1;
                w_fifo_waddr = r_cnt[CH_W-1:0];
                w_fifo_wdata = FIFO_W'(r_cnt[CH_W-1:0]);
                n_cnt        = r_cnt + CNT_W'(1);
                if (r_cnt[CH_W-1:0] == IDX_LAST) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_cnt       = '0;
                    n_found     = 1'b0;
                    n_have_free = 1'b0;
                    n_state     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // read data belongs to the slot issued in the previous cycle
                if (r_cnt != '0) begin
                    if (!r_found && r_map_vld[w_cmp_idx] && (w_rd_key == r_key)) begin
                        n_found     = 1'b1;
                        n_slot      = w_cmp_idx;
                        n_slot_chan = w_rd_chan;
                    end
                    if (!r_have_free && !r_map_vld[w_cmp_idx]) begin
                        n_have_free = 1'b1;
                        n_free_slot = w_cmp_idx;
                    end
                end
                if (r_cnt == CNT_FULL) begin
                    n_state = ST_EXEC;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_EXEC: begin
                if (w_commit) begin
                    n_out.ok          = 1'b0;
                    n_out.channel_out = '0;
                    n_out.was_playing = 1'b0;
                    n_out.stop_source = 1'b0;
                    case (r_item.mode)
                        vcpa_pkg::MODE_ASSIGN: begin
                            if (r_found) begin
                                n_out.ok          = 1'b1;
                                n_out.was_playing = 1'b1;
                                n_out.channel_out = r_slot_chan;
                            end else if (r_free_level != '0) begin
                                n_out.ok          = 1'b1;
                                n_out.channel_out = w_fifo_rdata[CB-1:0];
                                n_head       = (r_head == IDX_LAST) ? '0 : r_head + CH_W'(1);
                                n_free_level = r_free_level - CNT_W'(1);
                            end
                        end
                        vcpa_pkg::MODE_ADD: begin
                            if (r_found) begin
                                n_out.channel_out = r_slot_chan;
                            end else if (r_have_free) begin
                                w_map_we               = 1'b1;
                                n_map_vld[r_free_slot] = 1'b1;
                                n_map_count            = r_map_count + CNT_W'(1);
                                n_out.ok               = 1'b1;
                                n_out.channel_out      = r_item.channel_in;
                            end
                        end
                        vcpa_pkg::MODE_RELEASE: begin
                            if (r_found) begin
                                n_out.ok          = 1'b1;
                                n_out.channel_out = r_slot_chan;
                                n_out.stop_source = r_item.stop_flag;
                                // push is dropped when the free list is already full
                                if (r_free_level != CNT_FULL) begin
                                    w_fifo_we    = 1'b1;
                                    n_tail       = (r_tail == IDX_LAST) ? '0 : r_tail + CH_W'(1);
                                    n_free_level = r_free_level + CNT_W'(1);
                                end
                                n_map_vld[r_slot] = 1'b0;
                                n_map_count       = r_map_count - CNT_W'(1);
                            end
                        end
                        vcpa_pkg::MODE_QUERY: begin
                            if (r_found) begin
                                n_out.ok          = 1'b1;
                                n_out.channel_out = r_slot_chan;
                            end
                        end
                        default: begin
                            n_out.ok = 1'b0;
                        end
                    endcase
                    n_out.active_count = 6'(n_map_count);
                    n_out.free_count   = 6'(n_free_level);
                    n_out_valid        = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_INIT;
            r_cnt        <= '0;
            r_found      <= 1'b0;
            r_have_free  <= 1'b0;
            r_head       <= '0;
            r_tail       <= '0;
            r_free_level <= CNT_FULL;
            r_map_count  <= '0;
            r_map_vld    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_found      <= n_found;
            r_have_free  <= n_have_free;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_free_level <= n_free_level;
            r_map_count  <= n_map_count;
            r_map_vld    <= n_map_vld;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot      <= n_slot;
        r_slot_chan <= n_slot_chan;
        r_free_slot <= n_free_slot;
        r_out       <= n_out;
        if (w_accept) begin
            r_item <= i_in_data;
            r_key  <= KB'(i_in_data.source_id);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // table count tracks the valid bits
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_map_count) == 32'($countones(r_map_vld))))
        else $error("map count differs from number of valid slots");

    a_free_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free_level <= CNT_FULL))
        else $error("free list level above channel count");

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_SCAN) && (r_cnt == '0))
        else $error("accepted transaction did not start a scan");

    a_commit_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> r_out_valid && (r_state == ST_IDLE))
        else $error("commit did not present a result");

endmodule

FILE: dv/voice_channel_pool_allocator_checker.sv
// response checker for the voice channel pool allocator: mirrors the pool and compares results
`timescale 1ns / 100ps
module voice_channel_pool_allocator_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  vcpa_pkg::t_req i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  vcpa_pkg::t_rsp i_out_data,
    output int             o_fail_count,
    output int             o_pending
);
    import vcpa_pkg::*;

    // mirror of the free list and the source table
    logic [CHAN_BITS-1:0] free_fifo [NUM_CHANNELS];
    logic [CH_W-1:0]      free_head;
    logic [CH_W-1:0]      free_tail;
    logic [CNT_W-1:0]     free_level;
    logic                 map_valid [NUM_CHANNELS];
    logic [KEY_BITS-1:0]  map_key [NUM_CHANNELS];
    logic [CHAN_BITS-1:0] map_chan [NUM_CHANNELS];
    logic [CNT_W-1:0]     map_count;

    t_rsp pool_rsp_q [$];
    t_rsp exp_rsp;
    t_rsp pred_rsp;
    int   fails = 0;

    function automatic logic [CH_W-1:0] wrap_inc(input logic [CH_W-1:0] idx);
        return (idx == CH_W'(NUM_CHANNELS - 1)) ? '0 : idx + 1'b1;
    endfunction

    function automatic t_rsp next_pool_rsp(input t_req req);
        t_rsp rsp;
        int   slot;
        int   open_slot;
        rsp       = '0;
        slot      = -1;
        open_slot = -1;
        // walk downward so both end up on the lowest matching index
        for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
            if (map_valid[i] && map_key[i] == req.source_id) slot = i;
            if (!map_valid[i]) open_slot = i;
        end
        case (req.mode)
            MODE_ASSIGN: begin
                if (slot >= 0) begin
                    rsp.ok          = 1'b1;
                    rsp.was_playing = 1'b1;
                    rsp.channel_out = map_chan[slot];
                end else if (free_level != 0) begin
                    rsp.ok          = 1'b1;
                    rsp.channel_out = free_fifo[free_head];
                    free_head       = wrap_inc(free_head);
                    free_level      = free_level - 1'b1;
                end
            end
            MODE_ADD: begin
                if (slot >= 0) begin
                    rsp.channel_out = map_chan[slot];
                end else if (open_slot >= 0) begin
                    map_valid[open_slot] = 1'b1;
                    map_key[open_slot]   = req.source_id;
                    map_chan[open_slot]  = req.channel_in;
                    map_count            = map_count + 1'b1;
                    rsp.ok               = 1'b1;
                    rsp.channel_out      = req.channel_in;
                end
            end
            MODE_RELEASE: begin
                if (slot >= 0) begin
                    rsp.ok          = 1'b1;
                    rsp.channel_out = map_chan[slot];
                    rsp.stop_source = req.stop_flag;
                    // a full free list drops the returned channel
                    if (free_level < NUM_CHANNELS) begin
                        free_fifo[free_tail] = map_chan[slot];
                        free_tail            = wrap_inc(free_tail);
                        free_level           = free_level + 1'b1;
                    end
                    map_valid[slot] = 1'b0;
                    map_count       = map_count - 1'b1;
                end
            end
            MODE_QUERY: begin
                if (slot >= 0) begin
                    rsp.ok          = 1'b1;
                    rsp.channel_out = map_chan[slot];
                end
            end
            default: begin
                rsp.ok = 1'b0;
            end
        endcase
        rsp.active_count = map_count;
        rsp.free_count   = free_level;
        return rsp;
    endfunction

    function automatic void check_field(input string name, input int unsigned expv,
                                        input int unsigned actv);
        if (expv != actv) begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                free_fifo[i] = CHAN_BITS'(i);
                map_valid[i] = 1'b0;
            end
            free_head  = '0;
            free_tail  = '0;
            free_level = CNT_W'(NUM_CHANNELS);
            map_count  = '0;
            pool_rsp_q.delete();
        end else begin
            // retire the older transaction first; a same-edge request cannot match it
            if (i_out_valid && i_out_ready) begin
                if (pool_rsp_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, i_out_data);
                end else begin
                    exp_rsp = pool_rsp_q.pop_front();
                    check_field("ok", 32'(exp_rsp.ok), 32'(i_out_data.ok));
                    check_field("channel_out", 32'(exp_rsp.channel_out),
                                32'(i_out_data.channel_out));
                    check_field("was_playing", 32'(exp_rsp.was_playing),
                                32'(i_out_data.was_playing));
                    check_field("stop_source", 32'(exp_rsp.stop_source),
                                32'(i_out_data.stop_source));
                    check_field("active_count", 32'(exp_rsp.active_count),
                                32'(i_out_data.active_count));
                    check_field("free_count", 32'(exp_rsp.free_count),
                                32'(i_out_data.free_count));
                end
            end
            if (i_in_valid && i_in_ready) begin
                pred_rsp   = next_pool_rsp(i_in_data);
                pool_rsp_q = {pool_rsp_q, pred_rsp};
            end
        end
        o_fail_count <= fails;
        o_pending    <= pool_rsp_q.size();
    end

endmodule

FILE: dv/voice_channel_pool_allocator_tb.sv
// testbench top for the voice channel pool allocator: stimulus, flow control and verdict
`timescale 1ns / 100ps
module voice_channel_pool_allocator_tb;
    import vcpa_pkg::*;

    localparam int POOL_KEYS      = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 400;
    localparam int TAIL_CYCLES    = 80;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_req i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_rsp o_out_data;

    int fail_count;
    int pending;
    int burst_left  = 0;
    int idle_cycles = 0;

    logic [KEY_BITS-1:0] key_pool [POOL_KEYS];

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    voice_channel_pool_allocator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    voice_channel_pool_allocator_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // offer one transaction and hold it until taken; bursts end in a random gap
    task automatic send_req(input logic [1:0] mode, input logic [KEY_BITS-1:0] key,
                            input logic [4:0] chan, input logic stop);
        t_req req;
        int   gap;
        req.mode       = mode;
        req.source_id  = key;
        req.channel_in = chan;
        req.stop_flag  = stop;
        i_in_data  <= req;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
            gap = $urandom_range(0, 40);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // result side: stretches of different stall patterns, one long hold-off early on
    initial begin
        int stretch;
        int len;
        int kind;
        int tick;
        stretch = 0;
        tick    = 0;
        i_out_ready <= 1'b0;
        forever begin
            stretch++;
            if (stretch == 4) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                kind = $urandom_range(0, 3);
                len  = $urandom_range(10, 80);
                repeat (len) begin
                    tick++;
                    case (kind)
                        0:       i_out_ready <= 1'b1;
                        1:       i_out_ready <= 1'($urandom_range(0, 1));
                        2:       i_out_ready <= ($urandom_range(0, 3) == 0);
                        default: i_out_ready <= (tick % 3 == 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("voice_channel_pool_allocator regression: fail");
        $finish;
    end

    initial begin
        logic [1:0]          mode;
        logic [KEY_BITS-1:0] key;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int j = 2; j < POOL_KEYS; j++) key_pool[j] = KEY_BITS'($urandom);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_req(MODE_QUERY,   16'h0000, 5'd0,  1'b0);
        send_req(MODE_RELEASE, 16'hFFFF, 5'd31, 1'b1);  // unknown source
        send_req(MODE_ADD,     16'h0000, 5'd31, 1'b1);
        send_req(MODE_RELEASE, 16'h0000, 5'd0,  1'b1);  // free list full, push dropped
        send_req(MODE_ADD,     16'hFFFF, 5'd0,  1'b0);
        send_req(MODE_ADD,     16'hFFFF, 5'd21, 1'b1);  // already mapped
        send_req(MODE_ASSIGN,  16'hFFFF, 5'd31, 1'b1);  // already playing
        send_req(MODE_ASSIGN,  16'h1234, 5'd0,  1'b0);
        send_req(MODE_ASSIGN,  16'hEDCB, 5'd31, 1'b1);
        send_req(MODE_QUERY,   16'hFFFF, 5'd31, 1'b1);
        send_req(MODE_ADD,     16'hAAAA, 5'd21, 1'b0);
        send_req(MODE_ADD,     16'h5555, 5'd10, 1'b1);
        send_req(MODE_RELEASE, 16'hFFFF, 5'd0,  1'b0);
        send_req(MODE_RELEASE, 16'hAAAA, 5'd0,  1'b1);
        send_req(MODE_QUERY,   16'hAAAA, 5'd31, 1'b0);
        send_req(MODE_RELEASE, 16'h5555, 5'd31, 1'b0);
        wait_drained();

        // fill past capacity, then empty with the free list already full
        for (int j = 0; j < POOL_KEYS; j++)
            send_req(MODE_ADD, key_pool[j], 5'($urandom), 1'($urandom));
        for (int j = 0; j < POOL_KEYS; j++)
            send_req(MODE_RELEASE, key_pool[j], 5'($urandom), 1'($urandom));
        wait_drained();

        // fill again, run the free list dry, then hand every channel back
        for (int j = 0; j < POOL_KEYS; j++)
            send_req(MODE_ADD, key_pool[j], 5'($urandom), 1'($urandom));
        for (int j = 0; j < POOL_KEYS; j++)
            send_req(MODE_ASSIGN, KEY_BITS'($urandom), 5'($urandom), 1'($urandom));
        for (int j = 0; j < POOL_KEYS; j++)
            send_req(MODE_RELEASE, key_pool[j], 5'($urandom), 1'($urandom));
        wait_drained();

        for (int j = 0; j < 300; j++) begin
            mode = 2'($urandom_range(0, 3));
            key  = ($urandom_range(0, 3) != 0) ? key_pool[$urandom_range(0, POOL_KEYS - 1)]
                                               : KEY_BITS'($urandom);
            send_req(mode, key, 5'($urandom), 1'($urandom));
            if (j % 100 == 99) wait_drained();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("voice_channel_pool_allocator regression: pass");
        end else begin
            $display("voice_channel_pool_allocator regression: fail");
        end
        $finish;
    end

endmodule
